// File: design/bir_pkg.sv
package bir_pkg;

    // field and register widths
    localparam int COORD_W   = 10;
    localparam int PIX_W     = 16;
    localparam int RATIO_W   = 24;
    localparam int FRAC_BITS = 16;
    localparam int DIM_REG_W = 9;
    localparam int BOUND_W   = 11;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;

    // opcodes
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COL_RATIO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_RATIO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_ALIGN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET_MODE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COL_BOUND    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_BOUND    = 3'd7;

    // register reset values
    localparam logic [DIM_REG_W-1:0] RST_DIM   = 9'd256;
    localparam logic [RATIO_W-1:0]   RST_RATIO = 24'd65536;
    localparam logic [BOUND_W-1:0]   RST_BOUND = 11'd1024;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAP,
        ST_TAP,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_CAP,
        ST_HORZ,
        ST_VERT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [3:0] ld;     // capture p00, p01, p10, p11
        logic       h_en;
        logic       v_en;
    } blend_ctrl_t;

endpackage

// File: design/bir_frame_store.sv
module bir_frame_store #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [bir_pkg::PIX_W-1:0]  wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [bir_pkg::PIX_W-1:0]  rd_data
);
    import bir_pkg::*;

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/bir_axis.sv
module bir_axis #(
    parameter int MAX_IN_DIM = 256,
    parameter int DIM_W      = 8
) (
    input  logic                          clk,
    input  logic                          map_en,
    input  logic                          tap_en,
    input  logic [bir_pkg::COORD_W-1:0]   d,
    input  logic [bir_pkg::RATIO_W-1:0]   ratio,
    input  logic                          direct,
    input  logic [bir_pkg::DIM_REG_W-1:0] dim,
    input  logic [bir_pkg::BOUND_W-1:0]   bound,
    output logic [DIM_W-1:0]              t0,
    output logic [DIM_W-1:0]              t1,
    output logic [bir_pkg::FRAC_BITS-1:0] frac
);
    import bir_pkg::*;

    localparam int MUL_W  = COORD_W + 1;
    localparam int PROD_W = RATIO_W + MUL_W;
    localparam int INT_W  = PROD_W - FRAC_BITS;
    localparam int DIMC_W = (DIM_W + 1 > DIM_REG_W) ? DIM_W + 1 : DIM_REG_W;
    localparam logic [PROD_W-1:0] ONE_Q = PROD_W'(1) << FRAC_BITS;

    logic [MUL_W-1:0]     mul_op;
    logic [PROD_W-1:0]    prod_next, prod_reg;
    logic [PROD_W-1:0]    src;
    logic [INT_W-1:0]     s;
    logic [INT_W:0]       s_inc;
    logic [DIMC_W-1:0]    dim_ext, last_full;
    logic [DIM_W-1:0]     last;
    logic                 past;
    logic [DIM_W-1:0]     t0_next, t1_next, t0_reg, t1_reg;
    logic [FRAC_BITS-1:0] frac_next, frac_reg;

    // half-pixel mode multiplies by 2d+1 and halves afterwards
    assign mul_op    = direct ? {1'b0, d} : {d, 1'b1};
    assign prod_next = PROD_W'(ratio) * PROD_W'(mul_op);

    always_ff @(posedge clk)
    begin
        if (map_en)
        begin
            prod_reg <= prod_next;
        end
    end

    always_comb
    begin
        if (direct)
        begin
            src = prod_reg;
        end
        else if (prod_reg > ONE_Q)
        begin
            src = (prod_reg - ONE_Q) >> 1;
        end
        else
        begin
            src = '0;
        end
    end

    assign s         = src[PROD_W-1:FRAC_BITS];
    assign frac_next = src[FRAC_BITS-1:0];
    assign s_inc     = {1'b0, s} + (INT_W + 1)'(1);

    // last column or row, with the size register clamped to 1..MAX_IN_DIM
    assign dim_ext = DIMC_W'(dim);
    always_comb
    begin
        if (dim == '0)
        begin
            last_full = '0;
        end
        else if (dim_ext >= DIMC_W'(MAX_IN_DIM))
        begin
            last_full = DIMC_W'(MAX_IN_DIM - 1);
        end
        else
        begin
            last_full = dim_ext - DIMC_W'(1);
        end
    end
    assign last = last_full[DIM_W-1:0];

    assign past = BOUND_W'(d) >= bound;

    always_comb
    begin
        if (past)
        begin
            t0_next = last;
            t1_next = last;
        end
        else
        begin
            t0_next = (s < INT_W'(last)) ? s[DIM_W-1:0] : last;
            t1_next = (s_inc < (INT_W + 1)'(last)) ? s_inc[DIM_W-1:0] : last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tap_en)
        begin
            t0_reg   <= t0_next;
            t1_reg   <= t1_next;
            frac_reg <= frac_next;
        end
    end

    assign t0   = t0_reg;
    assign t1   = t1_reg;
    assign frac = frac_reg;

endmodule

// File: design/bir_blend.sv
module bir_blend (
    input  logic                          clk,
    input  bir_pkg::blend_ctrl_t          ctrl,
    input  logic [bir_pkg::PIX_W-1:0]     rd_data,
    input  logic [bir_pkg::FRAC_BITS-1:0] fx,
    input  logic [bir_pkg::FRAC_BITS-1:0] fy,
    output logic [bir_pkg::PIX_W-1:0]     result
);
    import bir_pkg::*;

    localparam int D_W  = PIX_W + 1;
    localparam int W_W  = FRAC_BITS + 1;
    localparam int H_W  = PIX_W + FRAC_BITS + 2;
    localparam int DV_W = H_W + 1;
    localparam int V_W  = DV_W + W_W;
    localparam int Q_W  = V_W - 2 * FRAC_BITS;
    localparam logic signed [V_W-1:0] HALF_LSB = V_W'(1) <<< (2 * FRAC_BITS - 1);
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((1 << (PIX_W - 1)) - 1);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_W'(1 << (PIX_W - 1));

    logic signed [PIX_W-1:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [D_W-1:0]   d0, d1;
    logic signed [W_W-1:0]   wx, wy;
    logic signed [H_W-1:0]   m0, m1, h0_next, h1_next, h0_reg, h1_reg;
    logic signed [DV_W-1:0]  dv;
    logic signed [V_W-1:0]   mv, v_next, v_reg, v_rnd;
    logic signed [Q_W-1:0]   q;

    always_ff @(posedge clk)
    begin
        if (ctrl.ld[0])
        begin
            p00_reg <= rd_data;
        end
        if (ctrl.ld[1])
        begin
            p01_reg <= rd_data;
        end
        if (ctrl.ld[2])
        begin
            p10_reg <= rd_data;
        end
        if (ctrl.ld[3])
        begin
            p11_reg <= rd_data;
        end
    end

    // a*(1-f) + b*f written as a + (b-a)*f: one multiplier per sum
    assign wx = W_W'({1'b0, fx});
    assign wy = W_W'({1'b0, fy});
    assign d0 = D_W'(p01_reg) - D_W'(p00_reg);
    assign d1 = D_W'(p11_reg) - D_W'(p10_reg);
    assign m0 = H_W'(d0) * H_W'(wx);
    assign m1 = H_W'(d1) * H_W'(wx);
    assign h0_next = (H_W'(p00_reg) <<< FRAC_BITS) + m0;
    assign h1_next = (H_W'(p10_reg) <<< FRAC_BITS) + m1;

    always_ff @(posedge clk)
    begin
        if (ctrl.h_en)
        begin
            h0_reg <= h0_next;
            h1_reg <= h1_next;
        end
    end

    assign dv     = DV_W'(h1_reg) - DV_W'(h0_reg);
    assign mv     = V_W'(dv) * V_W'(wy);
    assign v_next = (V_W'(h0_reg) <<< FRAC_BITS) + mv;

    always_ff @(posedge clk)
    begin
        if (ctrl.v_en)
        begin
            v_reg <= v_next;
        end
    end

    // round to nearest, floor shift, saturate
    assign v_rnd = v_reg + HALF_LSB;
    assign q     = v_rnd[V_W-1:2*FRAC_BITS];

    always_comb
    begin
        if (q > Q_MAX)
        begin
            result = Q_MAX[PIX_W-1:0];
        end
        else if (q < Q_MIN)
        begin
            result = Q_MIN[PIX_W-1:0];
        end
        else
        begin
            result = q[PIX_W-1:0];
        end
    end

endmodule

// File: design/bilinear_image_resize_unit.sv
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  opcode, col, row, pixel
// out      output     out_valid/out_stall value
// cfg      input      cfg_write          cfg_index, cfg_data
//
// An in-range load writes the frame store directly; an out-of-range load is dropped.
// A request goes through coordinate multiply, tap select, four reads through the single
// frame-store read port, horizontal and vertical blend, and output. The input is free
// again when the result is loaded, so a new request is taken only after the last is done. The result
// sits in an output register and the next item is taken meanwhile; a request only waits
// at its last step while that register is still full and out_stall is high.
// rst_n clears state, out_valid and the config registers; the frame store is not cleared.
module bilinear_image_resize_unit #(
    parameter int MAX_IN_DIM = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          opcode,
    input  logic [bir_pkg::COORD_W-1:0]   col,
    input  logic [bir_pkg::COORD_W-1:0]   row,
    input  logic [bir_pkg::PIX_W-1:0]     pixel,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bir_pkg::PIX_W-1:0]     value,
    input  logic                          cfg_write,
    input  logic [bir_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bir_pkg::CFG_W-1:0]     cfg_data
);
    import bir_pkg::*;

    localparam int DIM_W  = $clog2(MAX_IN_DIM);
    localparam int DEPTH  = MAX_IN_DIM * MAX_IN_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    // configuration registers
    logic [DIM_REG_W-1:0] in_width_reg, in_height_reg;
    logic [RATIO_W-1:0]   col_ratio_reg, row_ratio_reg;
    logic                 corner_align_reg, offset_mode_reg;
    logic [BOUND_W-1:0]   col_bound_reg, row_bound_reg;

    state_t               state_reg, state_next;
    logic [COORD_W-1:0]   req_col_reg, req_row_reg;
    logic                 out_valid_reg;
    logic [PIX_W-1:0]     value_reg;

    logic                 in_accept, load_en, req_accept, out_load, in_range;
    logic                 map_en, tap_en, rd_en, direct;
    logic                 sel_row1, sel_col1;
    blend_ctrl_t          bctrl;
    logic [DIM_W-1:0]     c0, c1, r0, r1, rd_row, rd_col;
    logic [FRAC_BITS-1:0] fx, fy;
    logic [ADDR_W-1:0]    wr_addr, rd_addr;
    logic [PIX_W-1:0]     rd_data, result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg     <= RST_DIM;
            in_height_reg    <= RST_DIM;
            col_ratio_reg    <= RST_RATIO;
            row_ratio_reg    <= RST_RATIO;
            corner_align_reg <= 1'b0;
            offset_mode_reg  <= 1'b0;
            col_bound_reg    <= RST_BOUND;
            row_bound_reg    <= RST_BOUND;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IN_WIDTH:     in_width_reg     <= cfg_data[DIM_REG_W-1:0];
                REG_IN_HEIGHT:    in_height_reg    <= cfg_data[DIM_REG_W-1:0];
                REG_COL_RATIO:    col_ratio_reg    <= cfg_data[RATIO_W-1:0];
                REG_ROW_RATIO:    row_ratio_reg    <= cfg_data[RATIO_W-1:0];
                REG_CORNER_ALIGN: corner_align_reg <= cfg_data[0];
                REG_OFFSET_MODE:  offset_mode_reg  <= cfg_data[0];
                REG_COL_BOUND:    col_bound_reg    <= cfg_data[BOUND_W-1:0];
                REG_ROW_BOUND:    row_bound_reg    <= cfg_data[BOUND_W-1:0];
                default:          ;
            endcase
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign req_accept = in_accept && (opcode == OP_REQUEST);
    assign in_range   = (32'(col) < MAX_IN_DIM) && (32'(row) < MAX_IN_DIM);
    assign load_en    = in_accept && (opcode == OP_LOAD) && in_range;
    assign wr_addr    = ADDR_W'(row) * ADDR_W'(MAX_IN_DIM) + ADDR_W'(col);

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            req_col_reg <= col;
            req_row_reg <= row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        map_en     = 1'b0;
        tap_en     = 1'b0;
        rd_en      = 1'b0;
        sel_row1   = 1'b0;
        sel_col1   = 1'b0;
        bctrl      = '0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                map_en     = 1'b1;
                state_next = ST_TAP;
            end
            ST_TAP:
            begin
                tap_en     = 1'b1;
                state_next = ST_RD0;
            end
            ST_RD0:
            begin
                rd_en      = 1'b1;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                rd_en       = 1'b1;
                sel_col1    = 1'b1;
                bctrl.ld[0] = 1'b1;
                state_next  = ST_RD2;
            end
            ST_RD2:
            begin
                rd_en       = 1'b1;
                sel_row1    = 1'b1;
                bctrl.ld[1] = 1'b1;
                state_next  = ST_RD3;
            end
            ST_RD3:
            begin
                rd_en       = 1'b1;
                sel_row1    = 1'b1;
                sel_col1    = 1'b1;
                bctrl.ld[2] = 1'b1;
                state_next  = ST_CAP;
            end
            ST_CAP:
            begin
                bctrl.ld[3] = 1'b1;
                state_next  = ST_HORZ;
            end
            ST_HORZ:
            begin
                bctrl.h_en = 1'b1;
                state_next = ST_VERT;
            end
            ST_VERT:
            begin
                bctrl.v_en = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            value_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    assign direct = corner_align_reg || offset_mode_reg;

    bir_axis #(
        .MAX_IN_DIM (MAX_IN_DIM),
        .DIM_W      (DIM_W)
    ) u_axis_col (
        .clk    (clk),
        .map_en (map_en),
        .tap_en (tap_en),
        .d      (req_col_reg),
        .ratio  (col_ratio_reg),
        .direct (direct),
        .dim    (in_width_reg),
        .bound  (col_bound_reg),
        .t0     (c0),
        .t1     (c1),
        .frac   (fx)
    );

    bir_axis #(
        .MAX_IN_DIM (MAX_IN_DIM),
        .DIM_W      (DIM_W)
    ) u_axis_row (
        .clk    (clk),
        .map_en (map_en),
        .tap_en (tap_en),
        .d      (req_row_reg),
        .ratio  (row_ratio_reg),
        .direct (direct),
        .dim    (in_height_reg),
        .bound  (row_bound_reg),
        .t0     (r0),
        .t1     (r1),
        .frac   (fy)
    );

    // read order: (r0,c0) (r0,c1) (r1,c0) (r1,c1)
    assign rd_row  = sel_row1 ? r1 : r0;
    assign rd_col  = sel_col1 ? c1 : c0;
    assign rd_addr = ADDR_W'(rd_row) * ADDR_W'(MAX_IN_DIM) + ADDR_W'(rd_col);

    bir_frame_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (load_en),
        .wr_addr (wr_addr),
        .wr_data (pixel),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bir_blend u_blend (
        .clk     (clk),
        .ctrl    (bctrl),
        .rd_data (rd_data),
        .fx      (fx),
        .fy      (fy),
        .result  (result)
    );

endmodule

// File: design/bir_checker.sv
module bir_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          opcode,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [bir_pkg::PIX_W-1:0]     value
);
    import bir_pkg::*;

    // a held result does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value))
        else $error("result changed while stalled");

    // a request keeps the input side busy
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_REQUEST |=> in_stall)
        else $error("input not stalled after request");

    // a load leaves the input free for the next item
    a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == OP_LOAD |=> !in_stall)
        else $error("input stalled after load");

    // a new result only ends a request in flight
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall) && !in_stall)
        else $error("result without request");

endmodule

bind bilinear_image_resize_unit bir_checker u_checker (.*);

// File: tb/bilinear_image_resize_unit_tb.sv
`timescale 1ns / 100ps

module bilinear_image_resize_unit_tb;
    import bir_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int STORE_DIM      = 256;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 110;
    localparam int DIRECTED_ROWS  = 18;

    typedef struct packed {
        logic [DIM_REG_W-1:0] width;
        logic [DIM_REG_W-1:0] height;
        logic [RATIO_W-1:0]   col_step;
        logic [RATIO_W-1:0]   row_step;
        logic                 corners;
        logic                 direct_map;
        logic [BOUND_W-1:0]   col_edge;
        logic [BOUND_W-1:0]   row_edge;
    } geom_t;

    typedef struct packed {
        logic               op;
        logic [COORD_W-1:0] c;
        logic [COORD_W-1:0] r;
        logic [PIX_W-1:0]   p;
        logic               typed;
        logic [PIX_W-1:0]   want;
    } dir_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 opcode = OP_LOAD;
    logic [COORD_W-1:0]   col = '0;
    logic [COORD_W-1:0]   row = '0;
    logic [PIX_W-1:0]     pixel = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [PIX_W-1:0]     value;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_IN_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;

    // predictor state
    geom_t          cur;
    logic [PIX_W-1:0] plane_mem [0:STORE_DIM*STORE_DIM-1];
    bit             plane_loaded [0:STORE_DIM*STORE_DIM-1];
    logic [PIX_W-1:0] pending_values [$];

    int fail_count = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    int send_pct = 27;
    int recv_pct = 81;

    // reset geometry: request (c, r) returns the pixel at (c, r), clamped to the last row and column
    dir_row_t dir_rows [DIRECTED_ROWS] = '{
        '{OP_LOAD,    10'd0,    10'd0,    16'h7FFF, 1'b0, 16'h0000},
        '{OP_REQUEST, 10'd0,    10'd0,    16'h1234, 1'b1, 16'h7FFF},
        '{OP_LOAD,    10'd255,  10'd255,  16'h8000, 1'b0, 16'h0000},
        '{OP_REQUEST, 10'd255,  10'd255,  16'hFFFF, 1'b1, 16'h8000},
        '{OP_REQUEST, 10'd1023, 10'd1023, 16'h0000, 1'b1, 16'h8000},
        '{OP_REQUEST, 10'd1023, 10'd0,    16'hA5A5, 1'b0, 16'h0000},
        '{OP_LOAD,    10'd256,  10'd0,    16'h5555, 1'b0, 16'h0000},
        '{OP_LOAD,    10'd0,    10'd256,  16'h5555, 1'b0, 16'h0000},
        '{OP_LOAD,    10'd1023, 10'd1023, 16'hAAAA, 1'b0, 16'h0000},
        '{OP_REQUEST, 10'd255,  10'd255,  16'h0F0F, 1'b1, 16'h8000},
        '{OP_LOAD,    10'd0,    10'd0,    16'h0000, 1'b0, 16'h0000},
        '{OP_REQUEST, 10'd0,    10'd0,    16'hFFFF, 1'b1, 16'h0000},
        '{OP_LOAD,    10'd0,    10'd0,    16'hFFFF, 1'b0, 16'h0000},
        '{OP_REQUEST, 10'd0,    10'd0,    16'h0001, 1'b1, 16'hFFFF},
        '{OP_LOAD,    10'd3,    10'd2,    16'h0180, 1'b0, 16'h0000},
        '{OP_REQUEST, 10'd3,    10'd2,    16'h8000, 1'b1, 16'h0180},
        '{OP_REQUEST, 10'd512,  10'd768,  16'h7FFF, 1'b0, 16'h0000},
        '{OP_REQUEST, 10'd7,    10'd9,    16'hFFFF, 1'b0, 16'h0000}
    };

    geom_t fixed_geoms [5] = '{
        '{9'd8,   9'd8,   24'h008000, 24'h008000, 1'b0, 1'b0, 11'd1024, 11'd1024},
        '{9'd1,   9'd0,   24'hFFFFFF, 24'h000000, 1'b1, 1'b0, 11'd0,    11'd2047},
        '{9'd0,   9'd511, 24'h018000, 24'h00C000, 1'b0, 1'b1, 11'd5,    11'd3},
        '{9'd511, 9'd2,   24'h000000, 24'h000001, 1'b1, 1'b1, 11'd2047, 11'd1024},
        '{9'd16,  9'd4,   24'h02AAAA, 24'hFFFFFF, 1'b0, 1'b0, 11'd9,    11'd0}
    };

    bilinear_image_resize_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .col       (col),
        .row       (row),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int eff_dim(input logic [DIM_REG_W-1:0] n);
        if (n == 0)
            return 1;
        return (n > STORE_DIM) ? STORE_DIM : int'(n);
    endfunction

    // output coordinates that still land inside the plane, plus a margin
    function automatic int out_span(input int dim, input logic [RATIO_W-1:0] step);
        longint s;
        if (step == 0)
            return 1023;
        s = (longint'(dim) << FRAC_BITS) / longint'(step) + 2;
        return (s > 1023) ? 1023 : int'(s);
    endfunction

    // source coordinate for one axis: both taps and the fraction weight
    function automatic void map_axis(input longint unsigned d, input longint unsigned step,
                                     input longint unsigned dim, input bit past,
                                     output int t0, output int t1, output longint frac);
        longint unsigned src, s, last, t;
        last = dim - 1;
        if (cur.corners || cur.direct_map)
            src = d * step;
        else
        begin
            t = step * (2 * d + 1);
            src = (t > 64'd65536) ? (t - 64'd65536) >> 1 : 64'd0;
        end
        s = src >> FRAC_BITS;
        frac = longint'(src & 64'hFFFF);
        if (past)
        begin
            t0 = int'(last);
            t1 = int'(last);
        end
        else
        begin
            t0 = int'((s < last) ? s : last);
            t1 = int'((s + 1 < last) ? s + 1 : last);
        end
    endfunction

    function automatic longint stored_pixel(input int r, input int c);
        longint p;
        p = $signed(plane_mem[r * STORE_DIM + c]);
        return p;
    endfunction

    function automatic logic [PIX_W-1:0] interpolate_pixel(input logic [COORD_W-1:0] c,
                                                           input logic [COORD_W-1:0] r);
        int     c0, c1, r0, r1;
        longint fx, fy, h0, h1, v;
        map_axis(c, cur.col_step, eff_dim(cur.width), c >= cur.col_edge, c0, c1, fx);
        map_axis(r, cur.row_step, eff_dim(cur.height), r >= cur.row_edge, r0, r1, fy);
        h0 = stored_pixel(r0, c0) * (64'sd65536 - fx) + stored_pixel(r0, c1) * fx;
        h1 = stored_pixel(r1, c0) * (64'sd65536 - fx) + stored_pixel(r1, c1) * fx;
        v = h0 * (64'sd65536 - fy) + h1 * fy + (64'sd1 <<< (2 * FRAC_BITS - 1));
        v = v >>> (2 * FRAC_BITS);
        if (v > 32767)
            v = 32767;
        else if (v < -32768)
            v = -32768;
        return v[PIX_W-1:0];
    endfunction

    function automatic geom_t random_geom();
        geom_t g;
        int    pick, span;
        pick = $urandom_range(99);
        g.width  = (pick < 85) ? 9'($urandom_range(1, 16)) :
                   (pick < 92) ? 9'd0 : 9'($urandom_range(256, 511));
        pick = $urandom_range(99);
        g.height = (pick < 85) ? 9'($urandom_range(1, 16)) :
                   (pick < 92) ? 9'd0 : 9'($urandom_range(256, 511));
        g.col_step = ($urandom_range(99) < 75) ? 24'($urandom_range(24'h2000, 24'h40000))
                                               : 24'($urandom);
        g.row_step = ($urandom_range(99) < 75) ? 24'($urandom_range(24'h2000, 24'h40000))
                                               : 24'($urandom);
        g.corners    = 1'($urandom);
        g.direct_map = 1'($urandom);
        span = out_span(eff_dim(g.width), g.col_step);
        g.col_edge = ($urandom_range(99) < 70) ? 11'($urandom_range(0, span + 2)) : 11'($urandom);
        span = out_span(eff_dim(g.height), g.row_step);
        g.row_edge = ($urandom_range(99) < 70) ? 11'($urandom_range(0, span + 2)) : 11'($urandom);
        return g;
    endfunction

    task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
                                   input logic [PIX_W-1:0] want);
        $display("mismatch at %0t: %s, got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    // one item through the input handshake; predictor updated on acceptance
    task automatic drive_item(input logic op, input logic [COORD_W-1:0] c,
                              input logic [COORD_W-1:0] r, input logic [PIX_W-1:0] p,
                              input logic typed, input logic [PIX_W-1:0] want);
        while (send_pct != 0 && $urandom_range(99) < send_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        col      <= c;
        row      <= r;
        pixel    <= p;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (op == OP_LOAD)
        begin
            if (c < STORE_DIM && r < STORE_DIM)
            begin
                plane_mem[r * STORE_DIM + c] = p;
                plane_loaded[r * STORE_DIM + c] = 1'b1;
            end
        end
        else
        begin
            pending_values.push_back(typed ? want : interpolate_pixel(c, r));
        end
    endtask

    // load any tap the request would read that was never written, then request
    task automatic issue_request(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] r,
                                 input logic [PIX_W-1:0] p, input logic typed,
                                 input logic [PIX_W-1:0] want);
        int     tc [2];
        int     tr [2];
        longint fx, fy;
        map_axis(c, cur.col_step, eff_dim(cur.width), c >= cur.col_edge, tc[0], tc[1], fx);
        map_axis(r, cur.row_step, eff_dim(cur.height), r >= cur.row_edge, tr[0], tr[1], fy);
        for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2; j++)
                if (!plane_loaded[tr[i] * STORE_DIM + tc[j]])
                    drive_item(OP_LOAD, 10'(tc[j]), 10'(tr[i]), 16'($urandom), 1'b0, '0);
        drive_item(OP_REQUEST, c, r, p, typed, want);
    endtask

    task automatic drain_block();
        in_valid <= 1'b0;
        while (pending_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic load_geometry(input geom_t g);
        write_reg(REG_IN_WIDTH, CFG_W'(g.width));
        write_reg(REG_IN_HEIGHT, CFG_W'(g.height));
        write_reg(REG_COL_RATIO, CFG_W'(g.col_step));
        write_reg(REG_ROW_RATIO, CFG_W'(g.row_step));
        write_reg(REG_CORNER_ALIGN, CFG_W'(g.corners));
        write_reg(REG_OFFSET_MODE, CFG_W'(g.direct_map));
        write_reg(REG_COL_BOUND, CFG_W'(g.col_edge));
        write_reg(REG_ROW_BOUND, CFG_W'(g.row_edge));
        cfg_write <= 1'b0;
        cur = g;
    endtask

    always @(posedge clk)
        out_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_values.size() == 0)
                report_mismatch("result with nothing pending", value, '0);
            else if (value !== pending_values[0])
                report_mismatch("value", value, pending_values.pop_front());
            else
                void'(pending_values.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int  target, mid, pick, cspan, rspan, dw, dh;
        bit  paused;
        logic [COORD_W-1:0] c, r;

        cur = '{RST_DIM, RST_DIM, RST_RATIO, RST_RATIO, 1'b0, 1'b0, RST_BOUND, RST_BOUND};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            if (dir_rows[i].op == OP_REQUEST)
                issue_request(dir_rows[i].c, dir_rows[i].r, dir_rows[i].p,
                              dir_rows[i].typed, dir_rows[i].want);
            else
                drive_item(OP_LOAD, dir_rows[i].c, dir_rows[i].r, dir_rows[i].p, 1'b0, '0);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            send_pct = (ph < 4) ? 27 : (ph < 8) ? 81 : 0;
            recv_pct = (ph < 4) ? 81 : (ph < 8) ? 27 : 0;
            drain_block();
            load_geometry((ph < 5) ? fixed_geoms[ph] : random_geom());
            dw = eff_dim(cur.width);
            dh = eff_dim(cur.height);
            cspan = out_span(dw, cur.col_step);
            rspan = out_span(dh, cur.row_step);
            target = items_sent + PHASE_ITEMS;
            mid = items_sent + PHASE_ITEMS / 2;
            paused = 1'b0;
            while (items_sent < target)
            begin
                pick = $urandom_range(99);
                if (pick < 55)
                    issue_request(10'($urandom_range(0, cspan)), 10'($urandom_range(0, rspan)),
                                  16'($urandom), 1'b0, '0);
                else if (pick < 65)
                    issue_request(10'($urandom), 10'($urandom), 16'($urandom), 1'b0, '0);
                else if (pick < 92)
                    drive_item(OP_LOAD, 10'($urandom_range(0, dw - 1)),
                               10'($urandom_range(0, dh - 1)), 16'($urandom), 1'b0, '0);
                else
                begin
                    // outside the store: dropped by the block
                    c = 10'($urandom);
                    r = 10'($urandom);
                    if (c < STORE_DIM && r < STORE_DIM)
                        r[8] = 1'b1;
                    drive_item(OP_LOAD, c, r, 16'($urandom), 1'b0, '0);
                end
                if (!paused && items_sent >= mid)
                begin
                    drain_block();
                    paused = 1'b1;
                end
            end
        end

        drain_block();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
design/bir_pkg.sv
design/bir_frame_store.sv
design/bir_axis.sv
design/bir_blend.sv
design/bilinear_image_resize_unit.sv
design/bir_checker.sv
tb/bilinear_image_resize_unit_tb.sv
